/* sv/lb_pkg.sv */
// Shared types and constants for the Liang-Barsky line clipper.
`default_nettype none
package lb_pkg;

  localparam int CW       = 15;  // input coordinate width
  localparam int OW       = 16;  // output coordinate and ratio width
  localparam int DIV_BITS = 16;  // quotient bits per ratio
  localparam int DIV_BPS  = 2;   // quotient bits resolved per divider stage
  localparam int DIV_STG  = DIV_BITS / DIV_BPS;
  localparam int NUM_DIV  = 4;

  localparam logic [OW-1:0] SAT_MAX = 16'h7fff;
  localparam logic [OW-1:0] SAT_MIN = 16'h8000;

  typedef enum logic [1:0] {
    REG_MIN_X = 2'd0,
    REG_MIN_Y = 2'd1,
    REG_MAX_X = 2'd2,
    REG_MAX_Y = 2'd3
  } cfg_reg_e;

  // one signed division, split into sign and magnitudes
  typedef struct packed {
    logic          neg;
    logic [CW-1:0] num;
    logic [CW-1:0] den;
  } div_req_t;

  // per-axis facts known before division
  typedef struct packed {
    logic pz;    // no motion on this axis
    logic pn;    // p < 0
    logic q1ok;  // q1 >= 0
    logic q2ok;  // q2 >= 0
  } axis_t;

  typedef struct packed {
    logic signed [CW-1:0] x1;
    logic signed [CW-1:0] y1;
    logic signed [CW-1:0] x2;
    logic signed [CW-1:0] y2;
    logic signed [OW-1:0] dx;
    logic signed [OW-1:0] dy;
    axis_t                ax;
    axis_t                ay;
  } ctx_t;

  typedef struct packed {
    logic                 ok;
    logic signed [OW-1:0] t0;
    logic signed [OW-1:0] t1;
  } clip_t;

endpackage
`default_nettype wire

/* sv/lb_prep.sv */
// Entry stage: deltas, edge distances and divider operands.
`default_nettype none
module lb_prep (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire logic signed [lb_pkg::CW-1:0] start_x_i,
  input  wire logic signed [lb_pkg::CW-1:0] start_y_i,
  input  wire logic signed [lb_pkg::CW-1:0] end_x_i,
  input  wire logic signed [lb_pkg::CW-1:0] end_y_i,
  input  wire logic signed [lb_pkg::CW-1:0] min_x_i,
  input  wire logic signed [lb_pkg::CW-1:0] min_y_i,
  input  wire logic signed [lb_pkg::CW-1:0] max_x_i,
  input  wire logic signed [lb_pkg::CW-1:0] max_y_i,
  output lb_pkg::div_req_t               req_o [lb_pkg::NUM_DIV],
  output lb_pkg::ctx_t                   ctx_o
);
  import lb_pkg::*;

  logic signed [OW-1:0] dx, dy, q1x, q2x, q1y, q2y;
  logic                 dxpos, dypos;
  div_req_t             req_d [NUM_DIV];
  ctx_t                 ctx_d;
  div_req_t             req_q [NUM_DIV];
  ctx_t                 ctx_q;

  function automatic logic [CW-1:0] mag(input logic signed [OW-1:0] v);
    logic [OW-1:0] a;
    a = v[OW-1] ? OW'(-v) : OW'(v);
    return a[CW-1:0];
  endfunction

  always_comb begin
    dx  = OW'(end_x_i) - OW'(start_x_i);
    dy  = OW'(end_y_i) - OW'(start_y_i);
    q1x = OW'(start_x_i) - OW'(min_x_i);
    q2x = OW'(max_x_i) - OW'(start_x_i);
    q1y = OW'(start_y_i) - OW'(min_y_i);
    q2y = OW'(max_y_i) - OW'(start_y_i);
    dxpos = !dx[OW-1] && (dx != '0);
    dypos = !dy[OW-1] && (dy != '0);
    // p = -d; ratios are q1/p and q2/(-p)
    req_d[0] = '{neg: q1x[OW-1] ^ dxpos,    num: mag(q1x), den: mag(dx)};
    req_d[1] = '{neg: q2x[OW-1] ^ dx[OW-1], num: mag(q2x), den: mag(dx)};
    req_d[2] = '{neg: q1y[OW-1] ^ dypos,    num: mag(q1y), den: mag(dy)};
    req_d[3] = '{neg: q2y[OW-1] ^ dy[OW-1], num: mag(q2y), den: mag(dy)};
    ctx_d.x1 = start_x_i;
    ctx_d.y1 = start_y_i;
    ctx_d.x2 = end_x_i;
    ctx_d.y2 = end_y_i;
    ctx_d.dx = dx;
    ctx_d.dy = dy;
    ctx_d.ax = '{pz: dx == '0, pn: dxpos, q1ok: !q1x[OW-1], q2ok: !q2x[OW-1]};
    ctx_d.ay = '{pz: dy == '0, pn: dypos, q1ok: !q1y[OW-1], q2ok: !q2y[OW-1]};
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      req_q <= req_d;
      ctx_q <= ctx_d;
    end
  end

  assign req_o = req_q;
  assign ctx_o = ctx_q;

endmodule
`default_nettype wire

/* sv/lb_div.sv */
// Pipelined restoring divider: (num << FRAC_BITS) / den, signed, saturated.
`default_nettype none
module lb_div #(
  parameter int FRAC_BITS = 8
) (
  input  wire                          clk_i,
  input  wire [lb_pkg::DIV_STG-1:0]    en_i,
  input  wire lb_pkg::div_req_t        req_i,
  output logic signed [lb_pkg::OW-1:0] quo_o
);
  import lb_pkg::*;

  localparam int DW = CW + FRAC_BITS;  // dividend width
  localparam int SW = CW + DIV_BITS;   // widest shifted divisor

  logic [DW-1:0]       rem_q [DIV_STG];
  logic [DIV_BITS-1:0] quo_q [DIV_STG];
  logic [CW-1:0]       den_q [DIV_STG];
  logic                neg_q [DIV_STG];
  logic                ovf_q [DIV_STG];

  for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
    logic [DW-1:0]       rem_in, rem_d;
    logic [DIV_BITS-1:0] quo_in, quo_d;
    logic [CW-1:0]       den_in;
    logic                neg_in, ovf_in;

    if (s == 0) begin : g_first
      assign rem_in = DW'(req_i.num) << FRAC_BITS;
      assign quo_in = '0;
      assign den_in = req_i.den;
      assign neg_in = req_i.neg;
      // quotient of 2^16 or more
      assign ovf_in = (req_i.num >> (DIV_BITS - FRAC_BITS)) >= req_i.den;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
      assign neg_in = neg_q[s-1];
      assign ovf_in = ovf_q[s-1];
    end

    always_comb begin
      logic [SW-1:0]       r;
      logic [SW-1:0]       dv;
      logic [DIV_BITS-1:0] qb;
      r  = SW'(rem_in);
      qb = quo_in;
      for (int k = 0; k < DIV_BPS; k++) begin
        dv = SW'(den_in) << (DIV_BITS - 1 - s * DIV_BPS - k);
        if (r >= dv) begin
          r  = r - dv;
          qb[DIV_BITS - 1 - s * DIV_BPS - k] = 1'b1;
        end
      end
      rem_d = r[DW-1:0];
      if (s == DIV_STG - 1) begin
        if (ovf_in || qb[DIV_BITS-1]) quo_d = neg_in ? SAT_MIN : SAT_MAX;
        else                          quo_d = neg_in ? DIV_BITS'(-qb) : qb;
      end else begin
        quo_d = qb;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        rem_q[s] <= rem_d;
        quo_q[s] <= quo_d;
        den_q[s] <= den_in;
        neg_q[s] <= neg_in;
        ovf_q[s] <= ovf_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_STG-1];

endmodule
`default_nettype wire

/* sv/lb_clip.sv */
// One axis of the Liang-Barsky parameter update, registered.
`default_nettype none
module lb_clip (
  input  wire                            clk_i,
  input  wire                            en_i,
  input  wire lb_pkg::clip_t             clip_i,
  input  wire lb_pkg::axis_t             axis_i,
  input  wire logic signed [lb_pkg::OW-1:0] r1_i,
  input  wire logic signed [lb_pkg::OW-1:0] r2_i,
  output lb_pkg::clip_t                  clip_o
);
  import lb_pkg::*;

  clip_t clip_d, clip_q;

  always_comb begin
    clip_d = clip_i;
    if (clip_i.ok) begin
      if (axis_i.pz) begin
        // parallel: start must lie between this pair of edges
        clip_d.ok = axis_i.q1ok && axis_i.q2ok;
      end else if (axis_i.pn) begin
        if (r1_i > clip_d.t1) begin
          clip_d.ok = 1'b0;
        end else begin
          if (r1_i > clip_d.t0) clip_d.t0 = r1_i;
          if (r2_i < clip_d.t0)      clip_d.ok = 1'b0;
          else if (r2_i < clip_d.t1) clip_d.t1 = r2_i;
        end
      end else begin
        if (r1_i < clip_d.t0) begin
          clip_d.ok = 1'b0;
        end else begin
          if (r1_i < clip_d.t1) clip_d.t1 = r1_i;
          if (r2_i > clip_d.t1)      clip_d.ok = 1'b0;
          else if (r2_i > clip_d.t0) clip_d.t0 = r2_i;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) clip_q <= clip_d;
  end

  assign clip_o = clip_q;

endmodule
`default_nettype wire

/* sv/lb_scale.sv */
// Endpoint update: rounded t*delta products, then the moved endpoints.
`default_nettype none
module lb_scale #(
  parameter int FRAC_BITS = 8
) (
  input  wire                          clk_i,
  input  wire [1:0]                    en_i,
  input  wire lb_pkg::clip_t           clip_i,
  input  wire lb_pkg::ctx_t            ctx_i,
  output logic                         visible_o,
  output logic signed [lb_pkg::OW-1:0] clip_start_x_o,
  output logic signed [lb_pkg::OW-1:0] clip_start_y_o,
  output logic signed [lb_pkg::OW-1:0] clip_end_x_o,
  output logic signed [lb_pkg::OW-1:0] clip_end_y_o
);
  import lb_pkg::*;

  localparam int PW = 2 * OW;
  localparam logic signed [OW-1:0] T_ONE  = OW'(1 << FRAC_BITS);
  localparam logic signed [PW-1:0] T_HALF = PW'(1 << (FRAC_BITS - 1));

  logic signed [OW-1:0] u;
  logic signed [PW-1:0] sx_d, sy_d, ex_d, ey_d;
  logic signed [PW-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [CW-1:0] x1_q, y1_q, x2_q, y2_q;
  logic                 ok_q;
  logic signed [OW-1:0] csx_q, csy_q, cex_q, cey_q;
  logic                 vis_q;

  always_comb begin
    u    = T_ONE - clip_i.t1;
    sx_d = PW'(clip_i.t0 * ctx_i.dx) + T_HALF;
    sy_d = PW'(clip_i.t0 * ctx_i.dy) + T_HALF;
    ex_d = PW'(u * ctx_i.dx) + T_HALF;
    ey_d = PW'(u * ctx_i.dy) + T_HALF;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sx_q <= sx_d;
      sy_q <= sy_d;
      ex_q <= ex_d;
      ey_q <= ey_d;
      x1_q <= ctx_i.x1;
      y1_q <= ctx_i.y1;
      x2_q <= ctx_i.x2;
      y2_q <= ctx_i.y2;
      ok_q <= clip_i.ok;
    end
  end

  // arithmetic shift gives the floor of the half-biased product
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      vis_q <= ok_q;
      csx_q <= ok_q ? OW'(PW'(x1_q) + (sx_q >>> FRAC_BITS)) : '0;
      csy_q <= ok_q ? OW'(PW'(y1_q) + (sy_q >>> FRAC_BITS)) : '0;
      cex_q <= ok_q ? OW'(PW'(x2_q) - (ex_q >>> FRAC_BITS)) : '0;
      cey_q <= ok_q ? OW'(PW'(y2_q) - (ey_q >>> FRAC_BITS)) : '0;
    end
  end

  assign visible_o      = vis_q;
  assign clip_start_x_o = csx_q;
  assign clip_start_y_o = csy_q;
  assign clip_end_x_o   = cex_q;
  assign clip_end_y_o   = cey_q;

endmodule
`default_nettype wire

/* sv/line_clip_liang_barsky_top.sv */
// Liang-Barsky line clipper top level: config registers, pipeline control.
//
// Input stream: one line segment per item on s_axis (start and end point).
// Output stream: one item per segment on m_axis; tuser carries the visible
// flag, tdata the clipped endpoints (all zero when the segment is rejected).
// Clip window is set through the cfg write port (index 0..3 = min x, min y,
// max x, max y); write it only while no item is in flight.
//
// The pipe has thirteen register stages: one entry stage, eight divider stages
// (two quotient bits each, four dividers in parallel), two axis update stages,
// a multiply stage and an output stage.
// Throughput: one item per cycle while the receiver holds m_axis_tready high.
// Each stage holds its own valid bit; a stalled receiver backs up only the
// full stages, so empty stages keep taking items until the pipe is full.
// Reset clears all valid bits and loads the default window (0,0)-(320,256).
`default_nettype none
module line_clip_liang_barsky_top #(
  parameter int FRAC_BITS = 8
) (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [63:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y, pad
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [63:0]  m_axis_tdata,   // clip_start_x, clip_start_y, clip_end_x, clip_end_y
  output logic [0:0]   m_axis_tuser,   // visible
  input  wire          cfg_we_i,
  input  wire  [1:0]   cfg_idx_i,
  input  wire  [14:0]  cfg_data_i
);
  import lb_pkg::*;

  localparam int NS     = 1 + DIV_STG + 4;
  localparam int ST_CX  = 1 + DIV_STG;
  localparam int ST_CY  = ST_CX + 1;
  localparam int ST_MUL = ST_CY + 1;

  logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic [NS-1:0]        vld_q;
  logic [NS:0]          rdy;
  ctx_t                 ctx_pre;
  ctx_t                 ctx_q [1:ST_CY];
  div_req_t             req [NUM_DIV];
  logic signed [OW-1:0] quo [NUM_DIV];
  logic signed [OW-1:0] ry1_q, ry2_q;
  clip_t                clip_init, clip_x, clip_y;
  logic signed [OW-1:0] csx, csy, cex, cey;
  logic                 vis;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= 15'sd0;
      min_y_q <= 15'sd0;
      max_x_q <= 15'sd320;
      max_y_q <= 15'sd256;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_MIN_X: min_x_q <= cfg_data_i;
        REG_MIN_Y: min_y_q <= cfg_data_i;
        REG_MAX_X: max_x_q <= cfg_data_i;
        REG_MAX_Y: max_y_q <= cfg_data_i;
        default:   ;
      endcase
    end
  end

  // a stage loads when it is empty or its content moves on
  always_comb begin
    rdy[NS] = m_axis_tready;
    for (int k = NS - 1; k >= 0; k--) rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NS; k++) begin
        if (rdy[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  lb_prep u_prep (
    .clk_i     (clk_i),
    .en_i      (rdy[0]),
    .start_x_i (s_axis_tdata[14:0]),
    .start_y_i (s_axis_tdata[29:15]),
    .end_x_i   (s_axis_tdata[44:30]),
    .end_y_i   (s_axis_tdata[59:45]),
    .min_x_i   (min_x_q),
    .min_y_i   (min_y_q),
    .max_x_i   (max_x_q),
    .max_y_i   (max_y_q),
    .req_o     (req),
    .ctx_o     (ctx_pre)
  );

  for (genvar d = 0; d < NUM_DIV; d++) begin : g_div
    lb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .en_i  (rdy[DIV_STG:1]),
      .req_i (req[d]),
      .quo_o (quo[d])
    );
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) ctx_q[1] <= ctx_pre;
    for (int k = 2; k <= ST_CY; k++) begin
      if (rdy[k]) ctx_q[k] <= ctx_q[k-1];
    end
    if (rdy[ST_CX]) begin
      ry1_q <= quo[2];
      ry2_q <= quo[3];
    end
  end

  assign clip_init = '{ok: 1'b1, t0: '0, t1: OW'(1 << FRAC_BITS)};

  lb_clip u_clip_x (
    .clk_i  (clk_i),
    .en_i   (rdy[ST_CX]),
    .clip_i (clip_init),
    .axis_i (ctx_q[DIV_STG].ax),
    .r1_i   (quo[0]),
    .r2_i   (quo[1]),
    .clip_o (clip_x)
  );

  lb_clip u_clip_y (
    .clk_i  (clk_i),
    .en_i   (rdy[ST_CY]),
    .clip_i (clip_x),
    .axis_i (ctx_q[ST_CX].ay),
    .r1_i   (ry1_q),
    .r2_i   (ry2_q),
    .clip_o (clip_y)
  );

  lb_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk_i          (clk_i),
    .en_i           (rdy[ST_MUL+1:ST_MUL]),
    .clip_i         (clip_y),
    .ctx_i          (ctx_q[ST_CY]),
    .visible_o      (vis),
    .clip_start_x_o (csx),
    .clip_start_y_o (csy),
    .clip_end_x_o   (cex),
    .clip_end_y_o   (cey)
  );

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NS-1];
  assign m_axis_tdata  = {cey, cex, csy, csx};
  assign m_axis_tuser  = vis;

endmodule
`default_nettype wire
